FILE: sv/record_table_search_sort_defines.svh
// ----------------------------------------------------------------------------
// Record table assertion macros
// Shared concurrent assertion forms for the record table modules.
// ----------------------------------------------------------------------------
`ifndef RECORD_TABLE_SEARCH_SORT_DEFINES_SVH
`define RECORD_TABLE_SEARCH_SORT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define RTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true outside reset.
`define RTS_NEVER(lbl, cond, msg) \
  `RTS_ASSERT(lbl, !(cond), msg)

`endif

FILE: sv/rts_pkg.sv
// ----------------------------------------------------------------------------
// Record table package
// Types and command codes shared by the record table modules.
// ----------------------------------------------------------------------------
package rts_pkg;

  typedef logic [1:0]  cmd_t;
  typedef logic [4:0]  slot_t;
  typedef logic [15:0] code_t;
  typedef logic [11:0] year_t;
  typedef logic [15:0] tag_t;

  typedef enum logic [1:0] {
    CMD_STORE  = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_SORT   = 2'd3
  } cmd_e;

  typedef struct packed {
    code_t code;
    year_t year;
    tag_t  tag;
  } rec_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

endpackage

FILE: sv/rts_if.sv
// ----------------------------------------------------------------------------
// Record table channels
// Valid/ready channels for commands into and results out of the record table.
// ----------------------------------------------------------------------------
interface rts_in_if;
  logic          valid;
  logic          ready;
  rts_pkg::cmd_t  command;
  rts_pkg::slot_t slot;
  rts_pkg::code_t code;
  rts_pkg::year_t year;
  rts_pkg::tag_t  tag;

  modport source (output valid, command, slot, code, year, tag, input ready);
  modport sink (input valid, command, slot, code, year, tag, output ready);
endinterface

interface rts_out_if;
  logic          valid;
  logic          ready;
  logic          hit;
  rts_pkg::slot_t slot_res;
  rts_pkg::code_t code_res;
  rts_pkg::year_t year_res;
  rts_pkg::tag_t  tag_res;
  logic          last;

  modport source (output valid, hit, slot_res, code_res, year_res, tag_res, last, input ready);
  modport sink (input valid, hit, slot_res, code_res, year_res, tag_res, last, output ready);
endinterface

FILE: sv/rts_mem.sv
// ----------------------------------------------------------------------------
// Record table memory
// Synchronous record store with one write and one registered read port.
// Entries not written since reset read as zero.
// ----------------------------------------------------------------------------
module rts_mem #(
  parameter int ENTRIES = 32,
  parameter int IW      = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rts_pkg::mem_req_t req_i,
  input  logic [IW-1:0]     waddr_i,
  input  logic [IW-1:0]     raddr_i,
  input  rts_pkg::rec_t     wdata_i,
  output rts_pkg::rec_t     rdata_o
);
  import rts_pkg::*;

  rec_t               mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  rec_t               rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rts_seq.sv
// ----------------------------------------------------------------------------
// Record table sequencer
// Walks the record memory for list, search and sort commands and holds the
// result register.
// ----------------------------------------------------------------------------
`include "record_table_search_sort_defines.svh"

module rts_seq #(
  parameter int ENTRIES = 32,
  parameter int IW      = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rts_in_if.sink            in_i,
  rts_out_if.source         out_o,
  output rts_pkg::mem_req_t mem_req_o,
  output logic [IW-1:0]     waddr_o,
  output logic [IW-1:0]     raddr_o,
  output rts_pkg::rec_t     wdata_o,
  input  rts_pkg::rec_t     rdata_i
);
  import rts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST,
    S_LIST_END,
    S_SEARCH,
    S_SORT_LOAD,
    S_SORT_STEP,
    S_SORT_END
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] pass_q, pass_d;
  rec_t          carry_q, carry_d;
  code_t         key_q, key_d;
  rec_t          pend_q, pend_d;
  logic [IW-1:0] pend_idx_q, pend_idx_d;
  logic          pend_vld_q, pend_vld_d;
  logic          ov_q, ov_d;
  logic          hit_q, hit_d;
  slot_t         slot_q, slot_d;
  rec_t          rec_q, rec_d;
  logic          last_q, last_d;

  mem_req_t      req;
  logic [IW-1:0] waddr, raddr;
  rec_t          wdata;
  logic          out_free;
  logic          push;
  logic          last_idx;
  logic          swap;
  logic          walk_start;
  logic          sort_state;

  assign out_free = !ov_q || out_o.ready;
  assign last_idx = (idx_q == IW'(ENTRIES - 1));
  assign swap     = carry_q.year > rdata_i.year;
  assign in_i.ready = (state_q == S_IDLE);
  assign walk_start = in_i.valid && in_i.ready && (in_i.command != CMD_STORE);
  assign sort_state = (state_q == S_SORT_STEP) || (state_q == S_SORT_END);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    carry_d    = carry_q;
    key_d      = key_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    pend_vld_d = pend_vld_q;
    ov_d       = ov_q && !out_o.ready;
    hit_d      = hit_q;
    slot_d     = slot_q;
    rec_d      = rec_q;
    last_d     = last_q;
    push       = 1'b0;
    req        = '0;
    waddr      = '0;
    raddr      = '0;
    wdata      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (cmd_e'(in_i.command))
            CMD_STORE: begin
              if (int'(in_i.slot) < ENTRIES) begin
                req.we = 1'b1;
                waddr  = IW'(in_i.slot);
                wdata  = '{code: in_i.code, year: in_i.year, tag: in_i.tag};
              end
            end
            CMD_LIST: begin
              req.re     = 1'b1;
              idx_d      = '0;
              pend_vld_d = 1'b0;
              state_d    = S_LIST;
            end
            CMD_SEARCH: begin
              req.re  = 1'b1;
              idx_d   = '0;
              key_d   = in_i.code;
              state_d = S_SEARCH;
            end
            CMD_SORT: begin
              req.re  = 1'b1;
              pass_d  = '0;
              state_d = S_SORT_LOAD;
            end
          endcase
        end
      end
      S_LIST: begin
        if (!(rdata_i.code != '0 && pend_vld_q && !out_free)) begin
          if (rdata_i.code != '0) begin
            if (pend_vld_q) begin
              push   = 1'b1;
              hit_d  = 1'b1;
              slot_d = 5'(pend_idx_q);
              rec_d  = pend_q;
              last_d = 1'b0;
            end
            pend_d     = rdata_i;
            pend_idx_d = idx_q;
            pend_vld_d = 1'b1;
          end
          if (last_idx) begin
            state_d = S_LIST_END;
          end else begin
            req.re = 1'b1;
            raddr  = idx_q + IW'(1);
            idx_d  = idx_q + IW'(1);
          end
        end
      end
      S_LIST_END: begin
        if (out_free) begin
          push    = 1'b1;
          hit_d   = pend_vld_q;
          slot_d  = pend_vld_q ? 5'(pend_idx_q) : '0;
          rec_d   = pend_vld_q ? pend_q : '0;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (rdata_i.code == key_q) begin
          if (out_free) begin
            push    = 1'b1;
            hit_d   = 1'b1;
            slot_d  = 5'(idx_q);
            rec_d   = rdata_i;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (last_idx) begin
          if (out_free) begin
            push    = 1'b1;
            hit_d   = 1'b0;
            slot_d  = '0;
            rec_d   = '0;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          req.re = 1'b1;
          raddr  = idx_q + IW'(1);
          idx_d  = idx_q + IW'(1);
        end
      end
      S_SORT_LOAD: begin
        carry_d = rdata_i;
        req.re  = 1'b1;
        raddr   = IW'(1);
        idx_d   = '0;
        state_d = S_SORT_STEP;
      end
      S_SORT_STEP: begin
        req.we  = 1'b1;
        waddr   = idx_q;
        wdata   = swap ? rdata_i : carry_q;
        carry_d = swap ? carry_q : rdata_i;
        if (idx_q == IW'(ENTRIES - 2)) begin
          state_d = S_SORT_END;
        end else begin
          req.re = 1'b1;
          raddr  = idx_q + IW'(2);
          idx_d  = idx_q + IW'(1);
        end
      end
      S_SORT_END: begin
        req.we = 1'b1;
        waddr  = IW'(ENTRIES - 1);
        wdata  = carry_q;
        if (pass_q == IW'(ENTRIES - 2)) begin
          state_d = S_IDLE;
        end else begin
          pass_d  = pass_q + IW'(1);
          req.re  = 1'b1;
          raddr   = '0;
          state_d = S_SORT_LOAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_vld_q <= 1'b0;
      ov_q       <= 1'b0;
      idx_q      <= '0;
      pass_q     <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      ov_q       <= ov_d;
      idx_q      <= idx_d;
      pass_q     <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q    <= carry_d;
    key_q      <= key_d;
    pend_q     <= pend_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    slot_q     <= slot_d;
    rec_q      <= rec_d;
    last_q     <= last_d;
  end

  assign mem_req_o      = req;
  assign waddr_o        = waddr;
  assign raddr_o        = raddr;
  assign wdata_o        = wdata;
  assign out_o.valid    = ov_q;
  assign out_o.hit      = hit_q;
  assign out_o.slot_res = slot_q;
  assign out_o.code_res = rec_q.code;
  assign out_o.year_res = rec_q.year;
  assign out_o.tag_res  = rec_q.tag;
  assign out_o.last     = last_q;

  `RTS_NEVER(a_rw_same_entry, req.we && req.re && (waddr == raddr), "read and write hit one entry")
  `RTS_NEVER(a_push_over_full, push && ov_q && !out_o.ready, "result register overwritten")
  `RTS_ASSERT(a_busy_after_cmd, walk_start |=> (state_q != S_IDLE), "command did not start")
  `RTS_NEVER(a_write_outside_sort, req.we && state_q != S_IDLE && !sort_state, "stray table write")

endmodule

FILE: sv/record_table_search_sort.sv
// ----------------------------------------------------------------------------
// Record table with search and sort
// A table of records (code, year, tag) with store, list, search and sort.
//
// Commands arrive on in_i and results leave on out_o, both valid/ready.
// One command transaction is taken only while no earlier command is busy.
// Store writes one slot in the cycle it is taken and gives no result.
// List reads one slot per cycle unless a result must wait for the result
// register, and emits every slot with a nonzero code, last marking the final
// one; an empty table gives one result with hit low. Search reads one slot
// per cycle and gives one result: the first slot whose code matches, or a
// miss with hit low once the last slot is read. Sort is a bubble sort by
// year that moves one adjacent pair per cycle through the table memory in
// ENTRIES - 1 passes, and gives no result.
// Reset clears the table at once through per-entry valid bits.
// When the receiver stalls, the result register holds its transaction and
// the walk waits until the register can take the next result.
// ----------------------------------------------------------------------------
module record_table_search_sort #(
  parameter int ENTRIES = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  rts_in_if.sink    in_i,
  rts_out_if.source out_o
);
  import rts_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  mem_req_t      mem_req;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  rec_t          wdata;
  rec_t          rdata;

  rts_mem #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .waddr_i(waddr),
    .raddr_i(raddr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  rts_seq #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .mem_req_o(mem_req),
    .waddr_o  (waddr),
    .raddr_o  (raddr),
    .wdata_o  (wdata),
    .rdata_i  (rdata)
  );

endmodule

FILE: tb/rts_table_checker.sv
// ----------------------------------------------------------------------------
// Record table result checker
// Watches the command and result channels of the record table. It keeps its
// own copy of the table, works out the results of every accepted command
// and compares each result transaction, field by field, with the oldest
// outstanding one.
// ----------------------------------------------------------------------------
module rts_table_checker #(
  parameter int ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rts_in_if           cmd_i,
  rts_out_if          res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import rts_pkg::*;

  typedef struct packed {
    logic  hit;
    slot_t slot;
    code_t code;
    year_t year;
    tag_t  tag;
    logic  last;
  } record_result_t;

  code_t          tbl_code [ENTRIES];
  year_t          tbl_year [ENTRIES];
  tag_t           tbl_tag  [ENTRIES];
  record_result_t due_records[$];
  int unsigned    mismatches;

  function automatic record_result_t slot_result(int idx, logic last);
    record_result_t r;
    r.hit  = 1'b1;
    r.slot = slot_t'(idx);
    r.code = tbl_code[idx];
    r.year = tbl_year[idx];
    r.tag  = tbl_tag[idx];
    r.last = last;
    return r;
  endfunction

  function automatic void run_command(cmd_e cmd, slot_t slot, code_t code, year_t year,
                                      tag_t tag);
    record_result_t miss;
    int             listed;
    code_t          c;
    year_t          y;
    tag_t           t;
    miss   = '0;
    miss.last = 1'b1;
    listed = 0;
    case (cmd)
      CMD_STORE: begin
        if (int'(slot) < ENTRIES) begin
          tbl_code[slot] = code;
          tbl_year[slot] = year;
          tbl_tag[slot]  = tag;
        end
      end
      CMD_LIST: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_code[i] != '0) begin
            due_records.push_back(slot_result(i, 1'b0));
            listed++;
          end
        end
        if (listed == 0) begin
          due_records.push_back(miss);
        end else begin
          due_records[due_records.size() - 1].last = 1'b1;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (listed == 0 && tbl_code[i] == code) begin
            due_records.push_back(slot_result(i, 1'b1));
            listed = 1;
          end
        end
        if (listed == 0) begin
          due_records.push_back(miss);
        end
      end
      CMD_SORT: begin
        for (int p = 0; p < ENTRIES - 1; p++) begin
          for (int j = 0; j < ENTRIES - 1; j++) begin
            if (tbl_year[j] > tbl_year[j + 1]) begin
              c = tbl_code[j];
              y = tbl_year[j];
              t = tbl_tag[j];
              tbl_code[j]     = tbl_code[j + 1];
              tbl_year[j]     = tbl_year[j + 1];
              tbl_tag[j]      = tbl_tag[j + 1];
              tbl_code[j + 1] = c;
              tbl_year[j + 1] = y;
              tbl_tag[j + 1]  = t;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(record_result_t got);
    record_result_t want;
    if (due_records.size() == 0) begin
      $error("result transaction with none outstanding: hit=%0d slot=%0d code=0x%0h last=%0d",
             got.hit, got.slot, got.code, got.last);
      mismatches++;
      return;
    end
    want = due_records.pop_front();
    compare_field("hit", want.hit, got.hit);
    compare_field("slot_res", want.slot, got.slot);
    compare_field("code_res", want.code, got.code);
    compare_field("year_res", want.year, got.year);
    compare_field("tag_res", want.tag, got.tag);
    compare_field("last", want.last, got.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_code[i] = '0;
        tbl_year[i] = '0;
        tbl_tag[i]  = '0;
      end
      due_records.delete();
      mismatches = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        check_result('{hit: res_i.hit, slot: res_i.slot_res, code: res_i.code_res,
                       year: res_i.year_res, tag: res_i.tag_res, last: res_i.last});
      end
      if (cmd_i.valid && cmd_i.ready) begin
        run_command(cmd_e'(cmd_i.command), cmd_i.slot, cmd_i.code, cmd_i.year, cmd_i.tag);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= due_records.size();
  end

endmodule

FILE: tb/tb_record_table_search_sort.sv
// ----------------------------------------------------------------------------
// Record table testbench
// Drives the record table with a directed set of commands and then random
// store, list, search and sort traffic, with random gaps on the command side
// and random stalls on the result side, including one long result stall.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_record_table_search_sort;
  import rts_pkg::*;

  localparam int TABLE_SLOTS  = 32;
  localparam int RANDOM_ITEMS = 360;
  localparam int QUIET_ITEMS  = 60;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int LONG_HOLD    = 300;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned idle_cycles;
  bit          quiet;
  bit          long_hold_req;
  code_t       code_pool [8];

  rts_in_if  cmd_if ();
  rts_out_if res_if ();

  record_table_search_sort #(
    .ENTRIES(TABLE_SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  rts_table_checker #(
    .ENTRIES(TABLE_SLOTS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_if),
    .res_i           (res_if),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : result_sink
    int hold_left;
    bit long_done;
    hold_left    = 0;
    long_done    = 1'b0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (long_hold_req && !long_done) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 9);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_command(cmd_e cmd, slot_t slot, code_t code, year_t year, tag_t tag);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.slot    <= slot;
    cmd_if.code    <= code;
    cmd_if.year    <= year;
    cmd_if.tag     <= tag;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic send_random_command();
    int    pick;
    cmd_e  cmd;
    code_t code;
    year_t year;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      cmd = CMD_STORE;
    end else if (pick < 64) begin
      cmd = CMD_LIST;
    end else if (pick < 93) begin
      cmd = CMD_SEARCH;
    end else begin
      cmd = CMD_SORT;
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      code = '0;
    end else if (pick < 60) begin
      code = code_pool[$urandom_range(0, 7)];
    end else begin
      code = code_t'($urandom);
    end
    if ($urandom_range(0, 1) == 0) begin
      year = year_t'($urandom_range(0, 15));
    end else begin
      year = year_t'($urandom);
    end
    send_command(cmd, slot_t'($urandom), code, year, tag_t'($urandom));
  endtask

  initial begin
    idle_cycles    = 0;
    quiet          = 1'b0;
    long_hold_req  = 1'b0;
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_STORE;
    cmd_if.slot    = '0;
    cmd_if.code    = '0;
    cmd_if.year    = '0;
    cmd_if.tag     = '0;
    foreach (code_pool[i]) begin
      code_pool[i] = code_t'($urandom_range(1, 65535));
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // An empty table: list and a missed search give one result with hit low,
    // while key zero finds the first empty slot.
    send_command(CMD_LIST,   5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_SEARCH, 5'd31, 16'h1234, 12'hFFF, 16'hFFFF);
    send_command(CMD_SEARCH, 5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_STORE,  5'd0,  16'hFFFF, 12'hFFF, 16'hFFFF);
    send_command(CMD_STORE,  5'd31, 16'h0001, 12'h000, 16'h0000);
    send_command(CMD_STORE,  5'd5,  16'h8000, 12'h7D0, 16'hA5A5);
    send_command(CMD_STORE,  5'd6,  16'h8000, 12'h7D0, 16'h5A5A);
    send_command(CMD_LIST,   5'd31, 16'hFFFF, 12'hFFF, 16'hFFFF);
    send_command(CMD_SEARCH, 5'd0,  16'h8000, 12'h000, 16'h0000);
    send_command(CMD_SEARCH, 5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_SEARCH, 5'd0,  16'hFFFF, 12'h000, 16'h0000);
    // Equal years must keep their order through the sort.
    send_command(CMD_SORT,   5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_LIST,   5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_SEARCH, 5'd0,  16'h0001, 12'h000, 16'h0000);
    send_command(CMD_STORE,  5'd31, 16'h0000, 12'h000, 16'h0000);
    send_command(CMD_STORE,  5'd1,  16'h7FFF, 12'h800, 16'h8000);
    send_command(CMD_LIST,   5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_SORT,   5'd31, 16'hFFFF, 12'hFFF, 16'hFFFF);
    send_command(CMD_LIST,   5'd0,  16'h0000, 12'h000, 16'h0000);
    send_command(CMD_SEARCH, 5'd0,  16'hFFFE, 12'h000, 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      if (i == 120) begin
        long_hold_req = 1'b1;
        send_command(CMD_LIST, 5'd0, 16'h0000, 12'h000, 16'h0000);
      end else begin
        send_random_command();
      end
    end

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
